// ===== sv/lce_pkg.sv =====
// shared types and constants for the lfu cache engine
`default_nettype none
package lce_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int          CAP_W     = 5;
  localparam int          WORD_W    = 32;
  localparam logic [4:0]  CAP_RESET = 5'd16;
  localparam logic        OP_GET    = 1'b0;
  localparam logic        OP_PUT    = 1'b1;

  typedef struct packed {
    logic start;
    logic scan_issue;
    logic sweep_issue;
    logic finish;
  } lce_cmd_t;

  typedef struct packed {
    logic out_free;
  } lce_status_t;

endpackage
`default_nettype wire

// ===== sv/lfu_cache_engine.sv =====
// top level of the lfu cache engine with lru tie break
`default_nettype none
// Fully associative key/value cache, least-frequently-used replacement with the
// least recently used entry chosen among equal use counts. One word is handled
// at a time: a scan reads every entry once to find the key, the victim and a
// free slot, a sweep reads every entry and writes back those that change to
// update ranks, counts and the new entry, and the finish step loads the result
// register. The next word is taken only when the sequencer is back in idle
// after the result is loaded; the single read port of the entry memories
// keeps words from overlapping. A finished result waits in the output
// register while the next word is taken; a further result waits in the
// sequencer until that one has been taken, and the input stalls meanwhile.
module lfu_cache_engine
  import lce_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,   // capacity_in_use
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [63:0]      in_tdata,    // lookup_key, store_value
  input  wire logic [0:0]       in_tuser,    // opcode
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata,   // read_value
  output logic [1:0]            out_tuser    // hit, evicted
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  lce_cmd_t         cmd;
  lce_status_t      status;
  logic [IDX_W-1:0] addr;

  lce_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .addr      (addr)
  );

  lce_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .addr       (addr),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser[0]),
    .in_key     (in_tdata[31:0]),
    .in_val     (in_tdata[63:32]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.scan_issue, cmd.sweep_issue, cmd.finish}))
    else $error("more than one command at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("word taken while busy");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_tvalid && in_tready))
    else $error("finish did not post a result");
`endif

endmodule
`default_nettype wire

// ===== sv/lce_ctrl.sv =====
// sequencer for the scan, sweep and result phases
`default_nettype none
module lce_ctrl
  import lce_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  input  wire lce_status_t                               status,
  output lce_cmd_t                                       cmd,
  output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] addr
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1) + 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWEEP, S_DONE} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign addr      = cnt_r[IDX_W-1:0];

  always_comb begin
    cmd             = '0;
    cmd.start       = in_tvalid && (state_r == S_IDLE);
    cmd.scan_issue  = (state_r == S_SCAN) && (cnt_r != LAST);
    cmd.sweep_issue = (state_r == S_SWEEP) && (cnt_r != LAST);
    cmd.finish      = (state_r == S_DONE) && status.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST) begin
          state_nxt = S_SWEEP;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SWEEP: begin
        if (cnt_r == LAST) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lce_datapath.sv =====
// entry memories, scan evaluation, rank sweep and result register
`default_nettype none
module lce_datapath
  import lce_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire lce_cmd_t                                  cmd,
  input  wire logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] addr,
  output lce_status_t                                    status,
  input  wire logic                                      cfg_we,
  input  wire logic [CAP_W-1:0]                          cfg_wdata,
  input  wire logic                                      in_op,
  input  wire logic [WORD_W-1:0]                         in_key,
  input  wire logic [WORD_W-1:0]                         in_val,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  output logic [WORD_W-1:0]                              out_tdata,
  output logic [1:0]                                     out_tuser
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int HW    = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (HW > CAP_W) ? HW : CAP_W;

  logic [WORD_W-1:0]     key_mem  [MAX_ENTRIES];
  logic [WORD_W-1:0]     val_mem  [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem  [MAX_ENTRIES];
  logic [IDX_W-1:0]      rank_mem [MAX_ENTRIES];

  logic [WORD_W-1:0]     key_rd, val_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [IDX_W-1:0]      rank_rd;

  logic [MAX_ENTRIES-1:0] valid_r;
  logic [HW-1:0]          held_r;
  logic [CAP_W-1:0]       cap_r;

  logic              op_r;
  logic [WORD_W-1:0] key_r, val_r;

  logic              pend_scan_r, pend_sweep_r;
  logic [IDX_W-1:0]  pend_idx_r;

  logic                  found_r, have_v_r, free_r;
  logic [IDX_W-1:0]      mslot_r, mrank_r, vslot_r, vrank_r, fslot_r;
  logic [WORD_W-1:0]     mval_r;
  logic [COUNT_BITS-1:0] vcnt_r;

  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_data_r;
  logic [1:0]            out_user_r;

  logic [CW-1:0]     cap_eff, held_ext;
  logic              touch, miss_ins, evict, gap_en, ins_en;
  logic [IDX_W-1:0]  gap_rank, ins_slot, touch_rank, ins_rank;
  logic              cur_valid, is_match, is_victim;
  logic              wr_en, wr_key, wr_val, wr_cnt;
  logic [WORD_W-1:0]     wr_key_d, wr_val_d;
  logic [COUNT_BITS-1:0] wr_cnt_d;
  logic [IDX_W-1:0]      wr_rank_d;

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // decision from the finished scan
  always_comb begin
    cap_eff  = (CW'(cap_r) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cap_r);
    held_ext = CW'(held_r);
    touch    = found_r && ((op_r == OP_GET) || (cap_eff != '0));
    miss_ins = (op_r == OP_PUT) && (cap_eff != '0) && !found_r;
    evict    = miss_ins && (held_ext >= cap_eff) && have_v_r;
    gap_en   = touch || evict;
    gap_rank = touch ? mrank_r : vrank_r;
    if (evict) begin
      ins_slot = (free_r && (fslot_r < vslot_r)) ? fslot_r : vslot_r;
    end else begin
      ins_slot = fslot_r;
    end
    ins_en     = miss_ins && (evict || free_r);
    touch_rank = IDX_W'(held_r - 1'b1);
    ins_rank   = IDX_W'(held_r - HW'(evict));
  end

  // scan evaluation of the entry read in the previous cycle
  always_comb begin
    cur_valid = valid_r[pend_idx_r];
    is_match  = cur_valid && (key_rd == key_r) && !found_r;
    is_victim = cur_valid && (!have_v_r || (cnt_rd < vcnt_r) ||
                ((cnt_rd == vcnt_r) && (rank_rd < vrank_r)));
  end

  // sweep write-back
  always_comb begin
    wr_en     = 1'b0;
    wr_key    = 1'b0;
    wr_val    = 1'b0;
    wr_cnt    = 1'b0;
    wr_key_d  = key_r;
    wr_val_d  = val_r;
    wr_cnt_d  = cnt_rd;
    wr_rank_d = rank_rd;
    if (pend_sweep_r) begin
      priority if (touch && (pend_idx_r == mslot_r)) begin
        wr_en     = 1'b1;
        wr_cnt    = 1'b1;
        wr_val    = (op_r == OP_PUT);
        wr_cnt_d  = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
        wr_rank_d = touch_rank;
      end else if (ins_en && (pend_idx_r == ins_slot)) begin
        wr_en     = 1'b1;
        wr_key    = 1'b1;
        wr_val    = 1'b1;
        wr_cnt    = 1'b1;
        wr_cnt_d  = COUNT_BITS'(1);
        wr_rank_d = ins_rank;
      end else if (gap_en && cur_valid && !(evict && (pend_idx_r == vslot_r))
                   && (rank_rd > gap_rank)) begin
        wr_en     = 1'b1;
        wr_rank_d = rank_rd - 1'b1;
      end else begin
        wr_en = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_rd  <= key_mem[addr];
    val_rd  <= val_mem[addr];
    cnt_rd  <= cnt_mem[addr];
    rank_rd <= rank_mem[addr];
    if (wr_en) begin
      rank_mem[pend_idx_r] <= wr_rank_d;
    end
    if (wr_key) begin
      key_mem[pend_idx_r] <= wr_key_d;
    end
    if (wr_val) begin
      val_mem[pend_idx_r] <= wr_val_d;
    end
    if (wr_cnt) begin
      cnt_mem[pend_idx_r] <= wr_cnt_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_val;
    end
    pend_idx_r <= addr;
    if (pend_scan_r) begin
      if (is_match) begin
        mslot_r <= pend_idx_r;
        mrank_r <= rank_rd;
        mval_r  <= val_rd;
      end
      if (is_victim) begin
        vslot_r <= pend_idx_r;
        vrank_r <= rank_rd;
        vcnt_r  <= cnt_rd;
      end
      if (!cur_valid && !free_r) begin
        fslot_r <= pend_idx_r;
      end
    end
    if (cmd.finish) begin
      out_data_r <= (op_r == OP_PUT) ? '0 : (found_r ? mval_r : '1);
      out_user_r <= {evict, found_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      valid_r      <= '0;
      held_r       <= '0;
      pend_scan_r  <= 1'b0;
      pend_sweep_r <= 1'b0;
      found_r      <= 1'b0;
      have_v_r     <= 1'b0;
      free_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      pend_scan_r  <= cmd.scan_issue;
      pend_sweep_r <= cmd.sweep_issue;
      if (cmd.start) begin
        found_r  <= 1'b0;
        have_v_r <= 1'b0;
        free_r   <= 1'b0;
      end else if (pend_scan_r) begin
        if (is_match) begin
          found_r <= 1'b1;
        end
        if (is_victim) begin
          have_v_r <= 1'b1;
        end
        if (!cur_valid) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (evict) begin
          valid_r[vslot_r] <= 1'b0;
        end
        if (ins_en) begin
          valid_r[ins_slot] <= 1'b1;
        end
        held_r <= held_r - HW'(evict) + HW'(ins_en);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
